>>> hdl/lightfield_pixel_voxel_hit_assert.svh
// Assertion macros shared by the RTL files.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef LIGHTFIELD_PIXEL_VOXEL_HIT_ASSERT_SVH
`define LIGHTFIELD_PIXEL_VOXEL_HIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LFVH_ASSERT_IMP(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("lfvh assertion failed");
`define LFVH_ASSERT_NXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("lfvh assertion failed");
`else
`define LFVH_ASSERT_IMP(lbl, clk, rst, cond, cons)
`define LFVH_ASSERT_NXT(lbl, clk, rst, cond, cons)
`endif
`endif

>>> hdl/lfvh_pkg.sv
package lfvh_pkg;

  // Pipeline depth, input register to output register.
  localparam int STAGES = 9;

  localparam int PIX_W    = 12;
  localparam int PHASE_W  = 20;
  localparam int PITCH_W  = 16;
  localparam int GAIN_W   = 15;
  localparam int VOXEL_W  = 21;
  localparam int DEPTH_W  = 16;
  localparam int GRAY_W   = 8;
  localparam int LENS_W   = 13;
  localparam int SLOPE_W  = 16;
  localparam int FMAG_W   = 24;
  localparam int SQ_W     = 2 * FMAG_W;
  localparam int P_W      = GAIN_W + FMAG_W;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 21;

  localparam logic [CFG_INDEX_W-1:0] REG_VOXEL_X       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOXEL_Y       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VOXEL_Z       = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VOXEL_COLOR   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_PITCH = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_X       = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_Y       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_GAIN    = 4'd7;

  // Load enable of every pipeline register stage, stage 1 in bit 0.
  typedef struct packed {
    logic [STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

>>> hdl/lightfield_pixel_voxel_hit.sv
// Throughput: one item per cycle while m_tready is high or a stage is empty.
// Nine register stages, each with its own valid bit.
// The slowest stages hold the multipliers (pitch scale, square and gain, slope by depth).
// A stalled output holds its stage; empty stages upstream keep accepting items.
// Reset (rst, synchronous): clears all valid bits and loads register defaults.
`include "lightfield_pixel_voxel_hit_assert.svh"
module lightfield_pixel_voxel_hit #(
  parameter int TAN_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_col[11:0], pixel_row[23:12], old_value[31:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  // new_value[7:0], lens_col[20:8], lens_row[33:21], slope_x[49:34], slope_y[65:50], zeros
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,   // hit[0], lens_valid[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lfvh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lfvh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(TAN_TABLE_ENTRIES);
  localparam int ST    = lfvh_pkg::STAGES;
  localparam logic [63:0] RAD_LIMIT = (64'd81 << 48) / 64'd400;

  // Configuration registers.
  logic signed [lfvh_pkg::VOXEL_W-1:0] voxel_x, voxel_y;
  logic signed [lfvh_pkg::DEPTH_W-1:0] voxel_z;
  logic [lfvh_pkg::GRAY_W-1:0]         voxel_color;
  logic [lfvh_pkg::PITCH_W-1:0]        inverse_pitch;
  logic [lfvh_pkg::PHASE_W-1:0]        phase_x, phase_y;
  logic [lfvh_pkg::GAIN_W-1:0]         angle_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_x       <= '0;
      voxel_y       <= '0;
      voxel_z       <= '0;
      voxel_color   <= 8'd255;
      inverse_pitch <= 16'd4978;
      phase_x       <= 20'd3242;
      phase_y       <= 20'd1920;
      angle_gain    <= 15'd6554;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfvh_pkg::REG_VOXEL_X:       voxel_x       <= cfg_data;
        lfvh_pkg::REG_VOXEL_Y:       voxel_y       <= cfg_data;
        lfvh_pkg::REG_VOXEL_Z:       voxel_z       <= cfg_data[15:0];
        lfvh_pkg::REG_VOXEL_COLOR:   voxel_color   <= cfg_data[7:0];
        lfvh_pkg::REG_INVERSE_PITCH: inverse_pitch <= cfg_data[15:0];
        lfvh_pkg::REG_PHASE_X:       phase_x       <= cfg_data[19:0];
        lfvh_pkg::REG_PHASE_Y:       phase_y       <= cfg_data[19:0];
        lfvh_pkg::REG_ANGLE_GAIN:    angle_gain    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [ST-1:0]        v;
  logic [ST-1:0]        load;
  lfvh_pkg::pipe_ctrl_t ctrl;

  always_comb begin
    load[ST-1] = !v[ST-1] || m_tready;
    for (int k = ST - 2; k >= 0; k--) begin
      load[k] = !v[k] || load[k+1];
    end
  end

  assign ctrl.load = load;
  assign s_tready  = load[0];
  assign m_tvalid  = v[ST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < ST; k++) begin
        if (load[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Gray value rides along with each item.
  logic [lfvh_pkg::GRAY_W-1:0] old_q [ST];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      old_q[0] <= s_tdata[31:24];
    end
    for (int k = 1; k < ST; k++) begin
      if (load[k]) begin
        old_q[k] <= old_q[k-1];
      end
    end
  end

  // Lens mapping, stages 1 to 5.
  logic signed [lfvh_pkg::LENS_W-1:0] lens_x5, lens_y5;
  logic                               neg_x5, neg_y5;
  logic [lfvh_pkg::SQ_W-1:0]          sq_x4, sq_y4;
  logic [IDX_W-1:0]                   idx_x5, idx_y5;

  lfvh_axis_map #(.ENTRIES(TAN_TABLE_ENTRIES)) u_map_x (
    .clk       (clk),
    .ctrl      (ctrl),
    .pix       (s_tdata[11:0]),
    .phase     (phase_x),
    .inv_pitch (inverse_pitch),
    .gain      (angle_gain),
    .lens      (lens_x5),
    .neg       (neg_x5),
    .sq        (sq_x4),
    .idx       (idx_x5)
  );

  lfvh_axis_map #(.ENTRIES(TAN_TABLE_ENTRIES)) u_map_y (
    .clk       (clk),
    .ctrl      (ctrl),
    .pix       (s_tdata[23:12]),
    .phase     (phase_y),
    .inv_pitch (inverse_pitch),
    .gain      (angle_gain),
    .lens      (lens_y5),
    .neg       (neg_y5),
    .sq        (sq_y4),
    .idx       (idx_y5)
  );

  // Stage 5: fraction radius check.
  logic [lfvh_pkg::SQ_W:0] rad;
  logic                    valid5, valid6, valid7, valid8, valid9;

  assign rad = {1'b0, sq_x4} + {1'b0, sq_y4};

  // Stage 6: tangent lookup.
  logic [lfvh_pkg::SLOPE_W-1:0]        tan_x6, tan_y6;
  logic                                neg_x6, neg_y6;
  logic signed [lfvh_pkg::LENS_W-1:0]  lens_x6, lens_y6;

  lfvh_tan_rom #(.ENTRIES(TAN_TABLE_ENTRIES)) u_tan_x (
    .clk       (clk),
    .load      (load[5]),
    .idx       (idx_x5),
    .tan_value (tan_x6)
  );

  lfvh_tan_rom #(.ENTRIES(TAN_TABLE_ENTRIES)) u_tan_y (
    .clk       (clk),
    .load      (load[5]),
    .idx       (idx_y5),
    .tan_value (tan_y6)
  );

  // Stages 7 to 9: signed slopes, zeroed on an invalid pixel, then carried out.
  logic signed [lfvh_pkg::SLOPE_W-1:0] slope_x7, slope_y7, slope_x8, slope_y8;
  logic signed [lfvh_pkg::SLOPE_W-1:0] slope_x9, slope_y9;
  logic signed [lfvh_pkg::LENS_W-1:0]  lens_x7, lens_y7, lens_x8, lens_y8, lens_x9, lens_y9;
  logic signed [lfvh_pkg::SLOPE_W-1:0] tan_xs, tan_ys;

  assign tan_xs = $signed(tan_x6);
  assign tan_ys = $signed(tan_y6);

  always_ff @(posedge clk) begin
    if (load[4]) begin
      valid5 <= 64'(rad) <= RAD_LIMIT;
    end
    if (load[5]) begin
      valid6  <= valid5;
      neg_x6  <= neg_x5;
      neg_y6  <= neg_y5;
      lens_x6 <= lens_x5;
      lens_y6 <= lens_y5;
    end
    if (load[6]) begin
      valid7   <= valid6;
      slope_x7 <= !valid6 ? '0 : (neg_x6 ? -tan_xs : tan_xs);
      slope_y7 <= !valid6 ? '0 : (neg_y6 ? -tan_ys : tan_ys);
      lens_x7  <= valid6 ? lens_x6 : '0;
      lens_y7  <= valid6 ? lens_y6 : '0;
    end
    if (load[7]) begin
      valid8   <= valid7;
      slope_x8 <= slope_x7;
      slope_y8 <= slope_y7;
      lens_x8  <= lens_x7;
      lens_y8  <= lens_y7;
    end
    if (load[8]) begin
      valid9   <= valid8;
      slope_x9 <= slope_x8;
      slope_y9 <= slope_y8;
      lens_x9  <= lens_x8;
      lens_y9  <= lens_y8;
    end
  end

  logic near_x9, near_y9;

  lfvh_ray_trace u_trace_x (
    .clk    (clk),
    .ctrl   (ctrl),
    .lens   (lens_x7),
    .slope  (slope_x7),
    .depth  (voxel_z),
    .target (voxel_x),
    .near   (near_x9)
  );

  lfvh_ray_trace u_trace_y (
    .clk    (clk),
    .ctrl   (ctrl),
    .lens   (lens_y7),
    .slope  (slope_y7),
    .depth  (voxel_z),
    .target (voxel_y),
    .near   (near_y9)
  );

  logic                        hit_w;
  logic [lfvh_pkg::GRAY_W-1:0] new_value;

  assign hit_w     = valid9 && near_x9 && near_y9;
  assign new_value = hit_w ? voxel_color : old_q[ST-1];
  assign m_tdata   = {6'd0, slope_y9, slope_x9, lens_y9, lens_x9, new_value};
  assign m_tuser   = {valid9, hit_w};

  `LFVH_ASSERT_NXT(a_accept_enters, clk, rst, s_tvalid && s_tready, v[0])
  `LFVH_ASSERT_IMP(a_empty_out_ready, clk, rst, !m_tvalid, s_tready)
  `LFVH_ASSERT_IMP(a_hit_needs_lens, clk, rst, m_tvalid && hit_w, valid9)
  `LFVH_ASSERT_IMP(a_invalid_zero, clk, rst, m_tvalid && !valid9, lens_x9 == '0 && lens_y9 == '0 && slope_x9 == '0 && slope_y9 == '0)

endmodule

>>> hdl/lfvh_tan_rom.sv
module lfvh_tan_rom #(
  parameter int ENTRIES = 256,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic                               clk,
  input  logic                               load,
  input  logic [IDX_W-1:0]                   idx,
  output logic [lfvh_pkg::SLOPE_W-1:0]       tan_value
);

  localparam logic [63:0] DEN = 64'(ENTRIES - 1);
  localparam logic [63:0] Q60_ONE = 64'd1 << 60;

  // (a * b) >> 60, truncated.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[123:60];
  endfunction

  // Restoring long division, used only while the table is built.
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem = rem - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k is tan(k / (ENTRIES - 1) rad) in Q2.14, from Q60 Taylor series.
  function automatic logic [lfvh_pkg::SLOPE_W-1:0] tan_entry(input logic [63:0] k);
    logic [63:0] kk, q, r, ang, sq, sn, cs, ts, tc, res;
    kk  = k << 48;
    q   = kk / DEN;
    r   = kk % DEN;
    ang = (q << 12) + ((r << 12) / DEN);
    sq  = mul_q60(ang, ang);
    sn  = ang;
    cs  = Q60_ONE;
    ts  = ang;
    tc  = Q60_ONE;
    for (int m = 1; m < 30; m++) begin
      ts = udiv(mul_q60(ts, sq), 64'((2 * m) * (2 * m + 1)));
      tc = udiv(mul_q60(tc, sq), 64'((2 * m - 1) * (2 * m)));
      if ((m & 1) != 0) begin
        sn = sn - ts;
        cs = cs - tc;
      end else begin
        sn = sn + ts;
        cs = cs + tc;
      end
    end
    sn = sn >> 20;
    cs = cs >> 20;
    if (cs == 64'd0) begin
      res = '0;
    end else begin
      res = udiv(sn * 64'd16384 + (cs >> 1), cs);
    end
    return res[lfvh_pkg::SLOPE_W-1:0];
  endfunction

  logic [lfvh_pkg::SLOPE_W-1:0] rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
    localparam logic [lfvh_pkg::SLOPE_W-1:0] Value = tan_entry(64'(k));
    assign rom[k] = Value;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tan_value <= rom[idx];
    end
  end

endmodule

>>> hdl/lfvh_axis_map.sv
module lfvh_axis_map #(
  parameter int ENTRIES = 256,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic                                  clk,
  input  lfvh_pkg::pipe_ctrl_t                  ctrl,
  input  logic [lfvh_pkg::PIX_W-1:0]            pix,
  input  logic [lfvh_pkg::PHASE_W-1:0]          phase,
  input  logic [lfvh_pkg::PITCH_W-1:0]          inv_pitch,
  input  logic [lfvh_pkg::GAIN_W-1:0]           gain,
  output logic signed [lfvh_pkg::LENS_W-1:0]    lens,
  output logic                                  neg,
  output logic [lfvh_pkg::SQ_W-1:0]             sq,
  output logic [IDX_W-1:0]                      idx
);

  localparam int D_W   = lfvh_pkg::PIX_W + 9;
  localparam int N_W   = D_W + lfvh_pkg::PITCH_W + 1;
  localparam int F_W   = lfvh_pkg::FMAG_W + 1;
  localparam int Q_W   = lfvh_pkg::P_W + IDX_W;
  localparam int PRE_W = Q_W - 37;

  localparam logic signed [N_W-1:0] OFF_POS = N_W'(1) <<< 23;
  localparam logic signed [N_W-1:0] OFF_NEG = (N_W'(1) <<< 23) - N_W'(1);
  localparam logic [Q_W-1:0]        QMUL    = Q_W'(ENTRIES - 1);
  localparam logic [Q_W-1:0]        ROUND   = Q_W'(1) << 36;
  localparam logic [PRE_W-1:0]      IDX_MAX = PRE_W'(ENTRIES - 1);

  logic signed [D_W-1:0]             d1;
  logic signed [N_W-1:0]             n2;
  logic signed [lfvh_pkg::LENS_W-1:0] lens3, lens4;
  logic                              neg3, neg4;
  logic [lfvh_pkg::FMAG_W-1:0]       fmag3;
  logic [lfvh_pkg::P_W-1:0]          p4;

  logic signed [N_W-1:0]             off;
  logic signed [N_W-1:0]             t;
  logic signed [F_W-1:0]             frac;
  logic [lfvh_pkg::FMAG_W-1:0]       fmag;
  logic signed [lfvh_pkg::PITCH_W:0] pitch_s;
  logic [Q_W-1:0]                    q;
  logic [PRE_W-1:0]                  pre;

  assign pitch_s = $signed({1'b0, inv_pitch});

  // Round half away from zero: negative values get one less of offset so that
  // the floor of the shift lands on the far integer at a tie.
  assign off  = n2[N_W-1] ? OFF_NEG : OFF_POS;
  assign t    = n2 + off;
  assign frac = $signed({1'b0, t[23:0]}) - $signed(off[F_W-1:0]);
  assign fmag = frac[F_W-1] ? lfvh_pkg::FMAG_W'(-frac) : frac[lfvh_pkg::FMAG_W-1:0];

  assign q   = {{(Q_W - lfvh_pkg::P_W){1'b0}}, p4} * QMUL + ROUND;
  assign pre = q[Q_W-1:37];

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      d1 <= $signed({1'b0, pix, 8'd0}) - $signed({1'b0, phase});
    end
    if (ctrl.load[1]) begin
      n2 <= d1 * pitch_s;
    end
    if (ctrl.load[2]) begin
      lens3 <= t[36:24];
      neg3  <= frac[F_W-1];
      fmag3 <= fmag;
    end
    if (ctrl.load[3]) begin
      sq    <= fmag3 * fmag3;
      p4    <= gain * fmag3;
      lens4 <= lens3;
      neg4  <= neg3;
    end
    if (ctrl.load[4]) begin
      idx  <= (pre > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : pre[IDX_W-1:0];
      lens <= lens4;
      neg  <= neg4;
    end
  end

endmodule

>>> hdl/lfvh_ray_trace.sv
module lfvh_ray_trace (
  input  logic                                   clk,
  input  lfvh_pkg::pipe_ctrl_t                   ctrl,
  input  logic signed [lfvh_pkg::LENS_W-1:0]     lens,
  input  logic signed [lfvh_pkg::SLOPE_W-1:0]    slope,
  input  logic signed [lfvh_pkg::DEPTH_W-1:0]    depth,
  input  logic signed [lfvh_pkg::VOXEL_W-1:0]    target,
  output logic                                   near
);

  localparam int PROD_W = lfvh_pkg::SLOPE_W + lfvh_pkg::DEPTH_W;
  localparam int DIFF_W = 37;
  // 0.35 in Q.22, rounded down.
  localparam logic signed [DIFF_W-1:0] NEAR_LIM = DIFF_W'((7 * 4194304) / 20);

  logic signed [PROD_W-1:0]          prod8;
  logic signed [lfvh_pkg::LENS_W-1:0] lens8;
  logic signed [DIFF_W-1:0]          lens_ext, prod_ext, tgt_ext, diff;

  assign lens_ext = {{(DIFF_W - lfvh_pkg::LENS_W - 22){lens8[lfvh_pkg::LENS_W-1]}}, lens8, 22'd0};
  assign prod_ext = {{(DIFF_W - PROD_W){prod8[PROD_W-1]}}, prod8};
  assign tgt_ext  = {{(DIFF_W - lfvh_pkg::VOXEL_W - 14){target[lfvh_pkg::VOXEL_W-1]}},
                     target, 14'd0};
  assign diff     = lens_ext + prod_ext - tgt_ext;

  always_ff @(posedge clk) begin
    if (ctrl.load[7]) begin
      prod8 <= slope * depth;
      lens8 <= lens;
    end
    if (ctrl.load[8]) begin
      near <= (diff >= -NEAR_LIM) && (diff <= NEAR_LIM);
    end
  end

endmodule

>>> verif/lightfield_pixel_voxel_hit_test.sv
`timescale 1ns / 1ps

module lightfield_pixel_voxel_hit_test;
  import lfvh_pkg::*;

  localparam int TAN_ENTRIES = 256;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int RECV_HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int DIRECTED_COUNT = 37;
  // Index past the last register; a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd12;

  typedef struct packed {
    logic [7:0]         new_value;
    logic               hit;
    logic               lens_valid;
    logic signed [12:0] lens_col;
    logic signed [12:0] lens_row;
    logic signed [15:0] slope_x;
    logic signed [15:0] slope_y;
  } voxel_outcome_t;

  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;

  typedef struct packed {
    step_kind_t                kind;
    logic [CFG_INDEX_W-1:0]    addr;
    logic [CFG_DATA_W-1:0]     wdata;
    logic [11:0]               col;
    logic [11:0]               row;
    logic [7:0]                old;
    logic                      glance;
    voxel_outcome_t            want;
  } directed_step_t;

  localparam directed_step_t DIRECTED_STEPS [DIRECTED_COUNT] = '{
    // Reset settings.
    '{STEP_PIXEL, '0, 21'd0, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd4095, 12'd4095, 8'hFF, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd4095, 12'd0, 8'h80, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd0, 12'd4095, 8'h7F, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd19, 12'd33, 8'h5A, 1'b0, '0},
    // Zero inverse pitch: everything lands on lens 0 and hits the voxel at the origin.
    '{STEP_WRITE, REG_INVERSE_PITCH, 21'd0, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd0, 12'd0, 8'h00, 1'b1,
      '{8'hFF, 1'b1, 1'b1, 13'd0, 13'd0, 16'd0, 16'd0}},
    '{STEP_PIXEL, '0, 21'd0, 12'd4095, 12'd4095, 8'h5A, 1'b1,
      '{8'hFF, 1'b1, 1'b1, 13'd0, 13'd0, 16'd0, 16'd0}},
    // Two-pixel pitch, no phase: even pixels sit on lens centers, odd ones on the edge.
    '{STEP_WRITE, REG_INVERSE_PITCH, 21'h8000, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_PHASE_X, 21'd0, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_PHASE_Y, 21'd0, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_VOXEL_X, 21'd1280, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_VOXEL_Y, 21'd1792, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_VOXEL_COLOR, 21'hC3, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd10, 12'd14, 8'h11, 1'b1,
      '{8'hC3, 1'b1, 1'b1, 13'd5, 13'd7, 16'd0, 16'd0}},
    '{STEP_PIXEL, '0, 21'd0, 12'd10, 12'd16, 8'h22, 1'b1,
      '{8'h22, 1'b0, 1'b1, 13'd5, 13'd8, 16'd0, 16'd0}},
    '{STEP_PIXEL, '0, 21'd0, 12'd11, 12'd14, 8'h33, 1'b1,
      '{8'h33, 1'b0, 1'b0, 13'd0, 13'd0, 16'd0, 16'd0}},
    '{STEP_PIXEL, '0, 21'd0, 12'd4095, 12'd4095, 8'hFF, 1'b1,
      '{8'hFF, 1'b0, 1'b0, 13'd0, 13'd0, 16'd0, 16'd0}},
    '{STEP_PIXEL, '0, 21'd0, 12'd4094, 12'd4094, 8'h00, 1'b1,
      '{8'h00, 1'b0, 1'b1, 13'd2047, 13'd2047, 16'd0, 16'd0}},
    '{STEP_WRITE, REG_UNMAPPED, 21'h1FFFFF, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd10, 12'd14, 8'h44, 1'b1,
      '{8'hC3, 1'b1, 1'b1, 13'd5, 13'd7, 16'd0, 16'd0}},
    // Gain above 1.0 pushes the tangent index past the end of the table.
    '{STEP_WRITE, REG_ANGLE_GAIN, 21'h7FFF, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_VOXEL_Z, 21'd512, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_PHASE_X, 21'd64, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd3, 12'd4, 8'h01, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd2, 12'd4, 8'h02, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd100, 12'd4000, 8'h03, 1'b0, '0},
    // Register extremes.
    '{STEP_WRITE, REG_VOXEL_X, 21'h100000, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_VOXEL_Y, 21'h0FFFFF, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_VOXEL_Z, 21'h08000, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_VOXEL_COLOR, 21'd0, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_INVERSE_PITCH, 21'hFFFF, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_PHASE_X, 21'hFFFFF, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_PHASE_Y, 21'hFFFFF, 12'd0, 12'd0, 8'h00, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd0, 12'd0, 8'hFF, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd4095, 12'd4095, 8'h00, 1'b0, '0},
    '{STEP_PIXEL, '0, 21'd0, 12'd4095, 12'd0, 8'hAA, 1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // pixel_col[11:0], pixel_row[23:12], old_value[31:24]
  logic        m_tvalid;
  logic        m_tready;
  // new_value[7:0], lens_col[20:8], lens_row[33:21], slope_x[49:34], slope_y[65:50], zeros
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;   // hit[0], lens_valid[1]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Register copies used for prediction.
  logic signed [20:0] voxel_x_q8;
  logic signed [20:0] voxel_y_q8;
  logic signed [15:0] voxel_depth_q8;
  logic [7:0]         voxel_gray;
  logic [15:0]        inv_pitch_q16;
  logic [19:0]        phase_x_q8;
  logic [19:0]        phase_y_q8;
  logic [14:0]        angle_gain_q14;

  bit [15:0]      tan_q14 [TAN_ENTRIES];
  voxel_outcome_t pending_outcomes [$];
  logic           glance_pending;
  voxel_outcome_t glance_want;
  int             send_idle_pct;
  int             recv_idle_pct;
  logic           hold_request;
  int             fault_count;
  int             quiet_cycles;

  lightfield_pixel_voxel_hit #(
    .TAN_TABLE_ENTRIES(TAN_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Truncated (a * b) >> 60 on 64-bit operands.
  function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
    bit [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // tan(k / (entries - 1)) in Q2.14 from Q60 sine and cosine series.
  function automatic bit [15:0] tan_entry(int k);
    longint unsigned den, q, r, ang, sq, sn, cs, ts, tc, m;
    den = TAN_ENTRIES - 1;
    q = (64'(k) << 48) / den;
    r = (64'(k) << 48) % den;
    ang = (q << 12) + ((r << 12) / den);
    sq = q60_mul(ang, ang);
    sn = ang;
    cs = 64'd1 << 60;
    ts = ang;
    tc = 64'd1 << 60;
    for (m = 1; m < 30; m++) begin
      ts = q60_mul(ts, sq) / ((2 * m) * (2 * m + 1));
      tc = q60_mul(tc, sq) / ((2 * m - 1) * (2 * m));
      if (m[0]) begin
        sn -= ts;
        cs -= tc;
      end else begin
        sn += ts;
        cs += tc;
      end
    end
    sn >>= 20;
    cs >>= 20;
    if (cs == 0) return 16'd0;
    return 16'((sn * 16384 + cs / 2) / cs);
  endfunction

  // Lens index (rounded half away from zero) and Q.24 fraction on one axis.
  function automatic void lens_locate(input logic [11:0] pix, input logic [19:0] phase,
                                      output longint lens, output longint frac);
    longint pix_q8, phase_l, pitch_l, d, n, r;
    longint unsigned mag;
    pix_q8 = {pix, 8'd0};
    phase_l = phase;
    pitch_l = inv_pitch_q16;
    d = pix_q8 - phase_l;
    n = d * pitch_l;
    mag = (n < 0) ? -n : n;
    r = (mag + (64'd1 << 23)) >> 24;
    lens = (n < 0) ? -r : r;
    frac = n - lens * 16777216;
  endfunction

  function automatic longint ray_slope(longint frac);
    longint unsigned fm, ang, idx;
    longint t;
    fm = (frac < 0) ? -frac : frac;
    ang = 64'd2 * angle_gain_q14 * fm;
    idx = (ang * 64'(TAN_ENTRIES - 1) + (64'd1 << 37)) >> 38;
    if (idx > 64'(TAN_ENTRIES - 1)) idx = TAN_ENTRIES - 1;
    t = tan_q14[idx];
    return (frac < 0) ? -t : t;
  endfunction

  // Everything in Q.22: lens + slope * depth against the voxel, tolerance 0.35.
  function automatic bit axis_near(longint lens, longint slope, longint target);
    longint depth, b, diff;
    longint unsigned dm;
    depth = voxel_depth_q8;
    b = lens * 4194304 + slope * depth;
    diff = b - target * 16384;
    dm = (diff < 0) ? -diff : diff;
    return dm * 20 <= 64'd7 * 4194304;
  endfunction

  function automatic voxel_outcome_t trace_pixel(logic [11:0] col, logic [11:0] row,
                                                 logic [7:0] old);
    longint lc, lr, fc, fr, sx, sy, vx, vy;
    longint unsigned mc, mr, rad;
    bit valid, hit;
    voxel_outcome_t res;
    lens_locate(col, phase_x_q8, lc, fc);
    lens_locate(row, phase_y_q8, lr, fr);
    mc = (fc < 0) ? -fc : fc;
    mr = (fr < 0) ? -fr : fr;
    rad = mc * mc + mr * mr;
    valid = rad * 400 <= (64'd81 << 48);
    sx = 0;
    sy = 0;
    hit = 1'b0;
    vx = voxel_x_q8;
    vy = voxel_y_q8;
    if (valid) begin
      sx = ray_slope(fc);
      sy = ray_slope(fr);
      hit = axis_near(lc, sx, vx) && axis_near(lr, sy, vy);
    end else begin
      lc = 0;
      lr = 0;
    end
    res.new_value = hit ? voxel_gray : old;
    res.hit = hit;
    res.lens_valid = valid;
    res.lens_col = lc[12:0];
    res.lens_row = lr[12:0];
    res.slope_x = sx[15:0];
    res.slope_y = sy[15:0];
    return res;
  endfunction

  // Accepted items and results are both seen here, at the rising edge.
  always @(posedge clk) begin
    voxel_outcome_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.new_value = m_tdata[7:0];
        got.lens_col = m_tdata[20:8];
        got.lens_row = m_tdata[33:21];
        got.slope_x = m_tdata[49:34];
        got.slope_y = m_tdata[65:50];
        got.hit = m_tuser[0];
        got.lens_valid = m_tuser[1];
        if (pending_outcomes.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result item: new=%0d hit=%0d", got.new_value, got.hit);
        end else begin
          want = pending_outcomes.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("mismatch want: new=%0d hit=%0d valid=%0d lens=(%0d,%0d) slope=(%0d,%0d)",
                       want.new_value, want.hit, want.lens_valid, want.lens_col,
                       want.lens_row, want.slope_x, want.slope_y);
              $display("          got: new=%0d hit=%0d valid=%0d lens=(%0d,%0d) slope=(%0d,%0d)",
                       got.new_value, got.hit, got.lens_valid, got.lens_col,
                       got.lens_row, got.slope_x, got.slope_y);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_outcomes.push_back(glance_pending ? glance_want :
                                   trace_pixel(s_tdata[11:0], s_tdata[23:12], s_tdata[31:24]));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("lightfield_pixel_voxel_hit_test: FAIL");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold to fill the pipeline.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        m_tready = 1'b0;
        hold_done = 1'b1;
        repeat (RECV_HOLD_CYCLES) @(negedge clk);
      end
      m_tready = !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_register(logic [CFG_INDEX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = addr;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      REG_VOXEL_X:       voxel_x_q8 = value;
      REG_VOXEL_Y:       voxel_y_q8 = value;
      REG_VOXEL_Z:       voxel_depth_q8 = value[15:0];
      REG_VOXEL_COLOR:   voxel_gray = value[7:0];
      REG_INVERSE_PITCH: inv_pitch_q16 = value[15:0];
      REG_PHASE_X:       phase_x_q8 = value[19:0];
      REG_PHASE_Y:       phase_y_q8 = value[19:0];
      REG_ANGLE_GAIN:    angle_gain_q14 = value[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Leaves tvalid high so back-to-back items need no gap.
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [7:0] old,
                            logic glance, voxel_outcome_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {old, row, col};
    glance_pending = glance;
    glance_want = want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    s_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  initial begin
    int ph, n, c, r, fc, fr, sp, z, ip, phx, phy, gain, color;
    longint vx, vy;
    directed_step_t st;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    glance_pending = 1'b0;
    glance_want = '0;
    hold_request = 1'b0;
    fault_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 32;
    recv_idle_pct = 86;
    voxel_x_q8 = '0;
    voxel_y_q8 = '0;
    voxel_depth_q8 = '0;
    voxel_gray = 8'd255;
    inv_pitch_q16 = 16'd4978;
    phase_x_q8 = 20'd3242;
    phase_y_q8 = 20'd1920;
    angle_gain_q14 = 15'd6554;
    for (int k = 0; k < TAN_ENTRIES; k++) tan_q14[k] = tan_entry(k);
    repeat (4) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      st = DIRECTED_STEPS[i];
      if (st.kind == STEP_WRITE) begin
        drain_pipeline();
        write_register(st.addr, st.wdata);
      end else begin
        send_pixel(st.col, st.row, st.old, st.glance, st.want);
      end
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      // The sender waits here for every outstanding result before reprogramming.
      drain_pipeline();
      send_idle_pct = (ph < 4) ? 32 : ((ph < 7) ? 86 : 0);
      recv_idle_pct = (ph < 4) ? 86 : ((ph < 7) ? 32 : 0);
      ip = ($urandom_range(3) == 0) ? $urandom_range(1, 1199) : $urandom_range(1200, 65535);
      phx = $urandom_range(0, 10240);
      phy = $urandom_range(0, 10240);
      if (ph == 5) gain = 32767;
      else if (ph == 8) gain = $urandom_range(16385, 32767);
      else gain = $urandom_range(0, 16384);
      z = int'($urandom_range(0, 3072)) - 1536;
      color = $urandom_range(0, 255);
      // Aim the voxel at the lens under a random focus pixel so rays can reach it.
      fc = $urandom_range(0, 4095);
      fr = $urandom_range(0, 4095);
      vx = (((longint'(fc) * 256 - phx) * ip) >>> 16) + int'($urandom_range(0, 192)) - 96;
      vy = (((longint'(fr) * 256 - phy) * ip) >>> 16) + int'($urandom_range(0, 192)) - 96;
      if (ph == 0) begin
        vx = -1048576;
        vy = -1048576;
        z = -32768;
        color = 0;
        ip = 1;
        phx = 0;
        phy = 0;
        gain = 0;
      end else if (ph == 1) begin
        vx = 1048575;
        vy = 1048575;
        z = 32767;
        color = 255;
        ip = 65535;
        phx = 1048575;
        phy = 1048575;
        gain = 16384;
      end
      write_register(REG_VOXEL_X, 21'(vx));
      write_register(REG_VOXEL_Y, 21'(vy));
      write_register(REG_VOXEL_Z, 21'(z));
      write_register(REG_VOXEL_COLOR, 21'(color));
      write_register(REG_INVERSE_PITCH, 21'(ip));
      write_register(REG_PHASE_X, 21'(phx));
      write_register(REG_PHASE_Y, 21'(phy));
      write_register(REG_ANGLE_GAIN, 21'(gain));
      sp = 4 * 65536 / ip + 3;
      if (sp > 4095) sp = 4095;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 75) begin
          c = fc + int'($urandom_range(0, 2 * sp)) - sp;
          r = fr + int'($urandom_range(0, 2 * sp)) - sp;
          if (c < 0) c = 0;
          if (c > 4095) c = 4095;
          if (r < 0) r = 0;
          if (r > 4095) r = 4095;
        end else begin
          c = $urandom_range(0, 4095);
          r = $urandom_range(0, 4095);
        end
        if (ph == RANDOM_PHASES - 1 && n == 40) hold_request = 1'b1;
        send_pixel(c[11:0], r[11:0], 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (STAGES + 8) @(negedge clk);
    if (fault_count == 0 && pending_outcomes.size() == 0)
      $display("lightfield_pixel_voxel_hit_test: PASS");
    else
      $display("lightfield_pixel_voxel_hit_test: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/lfvh_pkg.sv
hdl/lfvh_tan_rom.sv
hdl/lfvh_axis_map.sv
hdl/lfvh_ray_trace.sv
hdl/lightfield_pixel_voxel_hit.sv
verif/lightfield_pixel_voxel_hit_test.sv
